// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define FPLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpls assertion failed");

// next-cycle implication under reset
`define FPLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpls assertion failed");

`endif

// ===== hdl/fpls_pkg.sv =====
`default_nettype none

package fpls_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT_HI  = 3'd1,
    PH_WAIT_LO  = 3'd2,
    PH_WAIT_HI2 = 3'd3,
    PH_LOAD     = 3'd4,
    PH_FINISH   = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_DUMMY  = 2'd1,
    CMD_BYTE   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic data;
    logic dclk;
    logic nconfig;
  } pins_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data_byte;
    pins_t       pins;
    phase_t      phase;
    logic        error;
  } cmd_t;

  typedef struct packed {
    pins_t  pins;
    phase_t phase;
    logic   last;
    logic   error;
  } result_t;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd15;
  localparam logic [STEP_W-1:0] DUMMY_LAST_STEP = 4'd1;

endpackage

`default_nettype wire

// ===== hdl/fpls_front.sv =====
`default_nettype none

module fpls_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [1:0]          in_mode,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_nstatus_level,
  input  wire logic                in_conf_done_level,
  input  wire logic                q_full,
  output logic                     q_push,
  output fpls_pkg::cmd_t           q_cmd
);

  fpls_pkg::phase_t phase_r, phase_nxt;
  fpls_pkg::pins_t  pins_r, pins_nxt;
  fpls_pkg::mode_t  mode;

  assign mode   = fpls_pkg::mode_t'(in_mode);
  assign q_push = push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpls_pkg::PH_IDLE;
      pins_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      pins_r  <= pins_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    pins_nxt        = pins_r;
    q_cmd.kind      = fpls_pkg::CMD_SINGLE;
    q_cmd.data_byte = in_data_byte;
    q_cmd.error     = 1'b1;
    unique case (phase_r)
      fpls_pkg::PH_WAIT_HI: begin
        if (mode == fpls_pkg::MODE_SAMPLE) begin
          q_cmd.error = 1'b0;
          if (in_nstatus_level) begin
            pins_nxt  = '0;
            phase_nxt = fpls_pkg::PH_WAIT_LO;
          end
        end
      end
      fpls_pkg::PH_WAIT_LO: begin
        if (mode == fpls_pkg::MODE_SAMPLE) begin
          q_cmd.error = 1'b0;
          if (!in_nstatus_level) begin
            pins_nxt         = '0;
            pins_nxt.nconfig = 1'b1;
            phase_nxt        = fpls_pkg::PH_WAIT_HI2;
          end
        end
      end
      fpls_pkg::PH_WAIT_HI2: begin
        if (mode == fpls_pkg::MODE_SAMPLE) begin
          q_cmd.error = 1'b0;
          if (in_nstatus_level) begin
            phase_nxt = fpls_pkg::PH_LOAD;
          end
        end
      end
      fpls_pkg::PH_LOAD: begin
        if (mode == fpls_pkg::MODE_DATA) begin
          q_cmd.error      = 1'b0;
          q_cmd.kind       = fpls_pkg::CMD_BYTE;
          pins_nxt.nconfig = 1'b1;
          pins_nxt.dclk    = 1'b1;
          pins_nxt.data    = in_data_byte[7];
        end else if (mode == fpls_pkg::MODE_END) begin
          q_cmd.error = 1'b0;
          phase_nxt   = fpls_pkg::PH_FINISH;
        end
      end
      fpls_pkg::PH_FINISH: begin
        if (mode == fpls_pkg::MODE_SAMPLE) begin
          q_cmd.error = 1'b0;
          if (in_nstatus_level && in_conf_done_level) begin
            phase_nxt = fpls_pkg::PH_DONE;
          end else begin
            q_cmd.kind       = fpls_pkg::CMD_DUMMY;
            pins_nxt.nconfig = 1'b1;
            pins_nxt.dclk    = 1'b1;
            pins_nxt.data    = 1'b0;
          end
        end
      end
      default: begin
        if (mode == fpls_pkg::MODE_START) begin
          q_cmd.error      = 1'b0;
          pins_nxt         = '0;
          pins_nxt.nconfig = 1'b1;
          phase_nxt        = fpls_pkg::PH_WAIT_HI;
        end
      end
    endcase
    q_cmd.pins  = pins_nxt;
    q_cmd.phase = phase_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/fpls_queue.sv =====
`default_nettype none
`include "assert_macros.svh"

module fpls_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire fpls_pkg::cmd_t wr_cmd,
  output logic                full,
  input  wire logic           rd_en,
  output fpls_pkg::cmd_t      rd_cmd,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  fpls_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);
  assign rd_cmd = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `FPLS_ASSERT_IMPL(a_no_overflow, clk, rst_n, wr_en, !full)
  `FPLS_ASSERT_IMPL(a_no_underflow, clk, rst_n, rd_en, !empty)
  `FPLS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT)

endmodule

`default_nettype wire

// ===== hdl/fpls_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module fpls_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire fpls_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output fpls_pkg::result_t   res,
  output logic                res_valid,
  input  wire logic           res_pop
);

  logic [fpls_pkg::STEP_W-1:0] step_r;
  fpls_pkg::result_t           res_r, res_nxt;
  logic                        valid_r;
  logic                        load;
  logic                        final_step;

  assign load      = !cmd_empty && (!valid_r || res_pop);
  assign cmd_pop   = load && final_step;
  assign res       = res_r;
  assign res_valid = valid_r;

  always_comb begin
    res_nxt.phase = cmd.phase;
    res_nxt.error = cmd.error;
    res_nxt.pins  = cmd.pins;
    final_step    = 1'b1;
    case (cmd.kind)
      fpls_pkg::CMD_BYTE: begin
        res_nxt.pins.nconfig = 1'b1;
        res_nxt.pins.dclk    = step_r[0];
        res_nxt.pins.data    = cmd.data_byte[step_r[3:1]];
        final_step           = (step_r == fpls_pkg::BYTE_LAST_STEP);
      end
      fpls_pkg::CMD_DUMMY: begin
        res_nxt.pins.nconfig = 1'b1;
        res_nxt.pins.dclk    = step_r[0];
        res_nxt.pins.data    = 1'b0;
        final_step           = (step_r == fpls_pkg::DUMMY_LAST_STEP);
      end
      default: begin
        final_step = 1'b1;
      end
    endcase
    res_nxt.last = final_step;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r  <= final_step ? '0 : step_r + 1'b1;
        valid_r <= 1'b1;
      end else if (res_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  `FPLS_ASSERT_IMPL(a_mid_cmd_held, clk, rst_n, step_r != '0, !cmd_empty)
  `FPLS_ASSERT_NEXT(a_pop_restarts, clk, rst_n, cmd_pop, step_r == '0)

endmodule

`default_nettype wire

// ===== hdl/fpga_passive_serial_loader.sv =====
`default_nettype none

// Passive serial configuration sequencer. Each input item is taken when full is low; the front
// end tracks the configuration phase and the pin levels and files one command per item into a
// small command queue (QUEUE_DEPTH entries). The back end expands each command into pin updates
// at one result per cycle while pop keeps up: a data byte gives 16 results (data with dclk low,
// then dclk high, bit 0 first), a sample in the finishing phase that does not finish gives two
// (a dummy clock), every other item gives one. Sustained throughput is therefore bounded by the
// back-end expander. An item wrong for the current phase gives a single result with error set
// and changes nothing. last marks the final result of an item.

module fpga_passive_serial_loader #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_nstatus_level,
  input  wire logic       in_conf_done_level,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_nconfig_pin,
  output logic            out_dclk_pin,
  output logic            out_data_pin,
  output logic [2:0]      out_phase,
  output logic            out_last,
  output logic            out_error
);

  fpls_pkg::cmd_t    wr_cmd, rd_cmd;
  fpls_pkg::result_t res;
  logic              q_push, q_pop, q_empty, res_valid;

  fpls_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .in_nstatus_level   (in_nstatus_level),
    .in_conf_done_level (in_conf_done_level),
    .q_full             (full),
    .q_push             (q_push),
    .q_cmd              (wr_cmd)
  );

  fpls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .rd_en  (q_pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  fpls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rd_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty           = !res_valid;
  assign out_nconfig_pin = res.pins.nconfig;
  assign out_dclk_pin    = res.pins.dclk;
  assign out_data_pin    = res.pins.data;
  assign out_phase       = res.phase;
  assign out_last        = res.last;
  assign out_error       = res.error;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [3:0] BAD_IN_WAIT =
    (4'b1 << fpls_pkg::MODE_START) | (4'b1 << fpls_pkg::MODE_DATA) |
    (4'b1 << fpls_pkg::MODE_END);
  localparam logic [3:0] BAD_IN_LOAD =
    (4'b1 << fpls_pkg::MODE_START) | (4'b1 << fpls_pkg::MODE_SAMPLE);
  localparam logic [3:0] BAD_IN_FINISH = BAD_IN_WAIT;
  localparam logic [3:0] BAD_IN_DONE =
    (4'b1 << fpls_pkg::MODE_SAMPLE) | (4'b1 << fpls_pkg::MODE_DATA) |
    (4'b1 << fpls_pkg::MODE_END);

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  logic            clk;
  logic            rst_n;
  logic            push;
  logic            full;
  fpls_pkg::mode_t in_mode;
  logic [7:0]      in_data_byte;
  logic            in_nstatus_level;
  logic            in_conf_done_level;
  logic            empty;
  logic            pop;
  logic            out_nconfig_pin;
  logic            out_dclk_pin;
  logic            out_data_pin;
  logic [2:0]      out_phase;
  logic            out_last;
  logic            out_error;

  fpls_pkg::phase_t  model_phase;
  fpls_pkg::pins_t   model_pins;
  fpls_pkg::result_t pin_updates[$];
  int                mismatch_count;
  int                stall_cycles;
  int                items_sent;
  int                burst_left;
  bit                steady_sender;
  int                hold_off;
  int                rx_tick;
  rx_style_t         rx_style;

  fpga_passive_serial_loader i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .in_nstatus_level   (in_nstatus_level),
    .in_conf_done_level (in_conf_done_level),
    .empty              (empty),
    .pop                (pop),
    .out_nconfig_pin    (out_nconfig_pin),
    .out_dclk_pin       (out_dclk_pin),
    .out_data_pin       (out_data_pin),
    .out_phase          (out_phase),
    .out_last           (out_last),
    .out_error          (out_error)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void note_update(logic last, logic err);
    fpls_pkg::result_t r;
    r.pins  = model_pins;
    r.phase = model_phase;
    r.last  = last;
    r.error = err;
    pin_updates.push_back(r);
  endfunction

  function automatic void apply_item(fpls_pkg::mode_t m, logic [7:0] b, logic nst,
                                     logic cdone);
    if (m == fpls_pkg::MODE_START &&
        (model_phase == fpls_pkg::PH_IDLE || model_phase == fpls_pkg::PH_DONE)) begin
      model_pins = '0;
      model_pins.nconfig = 1'b1;
      model_phase = fpls_pkg::PH_WAIT_HI;
      note_update(1'b1, 1'b0);
    end else if (m == fpls_pkg::MODE_SAMPLE && (model_phase == fpls_pkg::PH_WAIT_HI ||
                 model_phase == fpls_pkg::PH_WAIT_LO ||
                 model_phase == fpls_pkg::PH_WAIT_HI2)) begin
      if (model_phase == fpls_pkg::PH_WAIT_HI && nst) begin
        model_pins = '0;
        model_phase = fpls_pkg::PH_WAIT_LO;
      end else if (model_phase == fpls_pkg::PH_WAIT_LO && !nst) begin
        model_pins = '0;
        model_pins.nconfig = 1'b1;
        model_phase = fpls_pkg::PH_WAIT_HI2;
      end else if (model_phase == fpls_pkg::PH_WAIT_HI2 && nst) begin
        model_phase = fpls_pkg::PH_LOAD;
      end
      note_update(1'b1, 1'b0);
    end else if (m == fpls_pkg::MODE_SAMPLE && model_phase == fpls_pkg::PH_FINISH) begin
      if (nst && cdone) begin
        model_phase = fpls_pkg::PH_DONE;
        note_update(1'b1, 1'b0);
      end else begin
        model_pins = '0;
        model_pins.nconfig = 1'b1;
        note_update(1'b0, 1'b0);
        model_pins.dclk = 1'b1;
        note_update(1'b1, 1'b0);
      end
    end else if (m == fpls_pkg::MODE_DATA && model_phase == fpls_pkg::PH_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        model_pins.nconfig = 1'b1;
        model_pins.data = b[i];
        model_pins.dclk = 1'b0;
        note_update(1'b0, 1'b0);
        model_pins.dclk = 1'b1;
        note_update(i == 7, 1'b0);
      end
    end else if (m == fpls_pkg::MODE_END && model_phase == fpls_pkg::PH_LOAD) begin
      model_phase = fpls_pkg::PH_FINISH;
      note_update(1'b1, 1'b0);
    end else begin
      note_update(1'b1, 1'b1);
    end
  endfunction

  task automatic compare_field(string name, logic [2:0] exp_v, logic [2:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    fpls_pkg::result_t due;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (push && !full) begin
        apply_item(in_mode, in_data_byte, in_nstatus_level, in_conf_done_level);
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (pin_updates.size() == 0) begin
          $error("result with no item outstanding");
          mismatch_count++;
        end else begin
          due = pin_updates.pop_front();
          compare_field("nconfig_pin", 3'(due.pins.nconfig), 3'(out_nconfig_pin));
          compare_field("dclk_pin", 3'(due.pins.dclk), 3'(out_dclk_pin));
          compare_field("data_pin", 3'(due.pins.data), 3'(out_data_pin));
          compare_field("phase", due.phase, out_phase);
          compare_field("last", 3'(due.last), 3'(out_last));
          compare_field("error", 3'(due.error), 3'(out_error));
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (rx_tick % 64 == 0) rx_style = rx_style_t'($urandom_range(0, 2));
      if (hold_off > 0) begin
        hold_off--;
        pop = 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: pop = 1'b1;
          RX_RANDOM: pop = ($urandom_range(0, 3) != 0);
          default:   pop = ((rx_tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(fpls_pkg::mode_t m, logic [7:0] b, logic nst, logic cdone);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && !steady_sender) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push = 1'b1;
    in_mode = m;
    in_data_byte = b;
    in_nstatus_level = nst;
    in_conf_done_level = cdone;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    push = 1'b0;
    while (pin_updates.size() != 0) @(negedge clk);
  endtask

  function automatic fpls_pkg::mode_t pick_wrong_mode(logic [3:0] bad);
    fpls_pkg::mode_t m;
    do m = fpls_pkg::mode_t'($urandom_range(0, 3)); while (!bad[m]);
    return m;
  endfunction

  task automatic maybe_wrong(logic [3:0] bad, bit noisy);
    if (noisy && $urandom_range(0, 4) == 0)
      send_item(pick_wrong_mode(bad), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic wait_stage(logic met, bit noisy);
    int misses;
    misses = $urandom_range(0, 2);
    repeat (misses) begin
      maybe_wrong(BAD_IN_WAIT, noisy);
      send_item(fpls_pkg::MODE_SAMPLE, 8'($urandom_range(0, 255)), !met,
                1'($urandom_range(0, 1)));
    end
    send_item(fpls_pkg::MODE_SAMPLE, 8'($urandom_range(0, 255)), met,
              1'($urandom_range(0, 1)));
  endtask

  task automatic run_config(int nbytes, bit noisy);
    int dummies;
    logic [1:0] lv;
    maybe_wrong(BAD_IN_DONE, noisy);
    send_item(fpls_pkg::MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    wait_stage(1'b1, noisy);
    wait_stage(1'b0, noisy);
    wait_stage(1'b1, noisy);
    repeat (nbytes) begin
      maybe_wrong(BAD_IN_LOAD, noisy);
      send_item(fpls_pkg::MODE_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    send_item(fpls_pkg::MODE_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    dummies = $urandom_range(0, 3);
    repeat (dummies) begin
      maybe_wrong(BAD_IN_FINISH, noisy);
      do lv = 2'($urandom_range(0, 3)); while (lv == 2'b11);
      send_item(fpls_pkg::MODE_SAMPLE, 8'($urandom_range(0, 255)), lv[1], lv[0]);
    end
    send_item(fpls_pkg::MODE_SAMPLE, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic test_idle_rejects();
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_DATA, 8'hFF, 1'b0, 1'b0);
    send_item(fpls_pkg::MODE_END, 8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_power_up_handshake();
    send_item(fpls_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b0, 1'b1);
    send_item(fpls_pkg::MODE_DATA, 8'h81, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b0);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_END, 8'h00, 1'b0, 1'b0);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b0, 1'b0);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b0, 1'b1);
    send_item(fpls_pkg::MODE_START, 8'h00, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_byte_shifting();
    send_item(fpls_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_DATA, 8'h00, 1'b0, 1'b0);
    send_item(fpls_pkg::MODE_DATA, 8'hFF, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_DATA, 8'h5A, 1'b0, 1'b1);
    send_item(fpls_pkg::MODE_END, 8'hFF, 1'b0, 1'b0);
  endtask

  task automatic test_finish_clocks();
    send_item(fpls_pkg::MODE_DATA, 8'hA5, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_END, 8'h00, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b0);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b0, 1'b1);
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_done_rejects();
    send_item(fpls_pkg::MODE_SAMPLE, 8'h00, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_DATA, 8'hFF, 1'b1, 1'b1);
    send_item(fpls_pkg::MODE_END, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_full_queue_stall();
    steady_sender = 1'b1;
    hold_off = 200;
    run_config(10, 1'b0);
    steady_sender = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_runs();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      run_config(($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4),
                 1'b1);
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_mode = fpls_pkg::MODE_START;
    in_data_byte = '0;
    in_nstatus_level = 1'b0;
    in_conf_done_level = 1'b0;
    model_phase = fpls_pkg::PH_IDLE;
    model_pins = '0;
    mismatch_count = 0;
    stall_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    steady_sender = 1'b0;
    hold_off = 0;
    rx_tick = 0;
    rx_style = RX_ALWAYS;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_rejects();
    test_power_up_handshake();
    test_byte_shifting();
    test_finish_clocks();
    test_done_rejects();
    test_full_queue_stall();
    test_random_runs();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
